>>> rtl/gnome_sort_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gnome sort engine
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef GNOME_SORT_ENGINE_MACROS_SVH
`define GNOME_SORT_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define GSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gnome sort engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define GSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gnome sort engine: next-cycle check failed");

`endif

>>> rtl/gse_pkg.sv
// ----------------------------------------------------------------------------
// gse_pkg
// Sizes, request types and sequencer states shared by the gnome sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gse_pkg;

    // Number of elements held per run
    localparam int DEPTH   = 64;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      last_res;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_TAKE,
        ST_CMP,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } gse_state_t;

endpackage

`default_nettype wire

>>> rtl/gse_out_stage.sv
// ----------------------------------------------------------------------------
// gse_out_stage
// Result register between the sort sequencer and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gse_out_stage
    import gse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    input  wire out_item_t push_item,
    output logic           push_ready,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Accept a new result when empty or when the held one leaves this cycle
    assign push_ready = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_valid && push_ready)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until it is taken
    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            item_reg <= push_item;
        end
    end

    assign result_valid = valid_reg;
    assign result       = item_reg;

endmodule

`default_nettype wire

>>> rtl/gnome_sort_engine.sv
// ----------------------------------------------------------------------------
// gnome_sort_engine
// Collects a run of signed values, sorts it in place and streams it out.
// ----------------------------------------------------------------------------
// Each request with last low is taken and its value stored (values past
// DEPTH are dropped). The request with last high starts the sort, and further
// requests are stalled until the last sorted value has been passed to the
// result register. The sort walks the run in a store with one write port and
// one registered read port: for each element it takes the element, compares it
// with its left neighbour and shifts that neighbour right while it is larger,
// then drops the element into the gap. Each sorted value is then read from the
// store and pushed into the result register, waiting while it cannot accept.
`default_nettype none

`include "gnome_sort_engine_macros.svh"

module gnome_sort_engine
    import gse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire in_item_t item,
    output logic          result_valid,
    input  wire logic     result_stall,
    output out_item_t     result
);

    gse_state_t state_reg;
    gse_state_t state_next;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   frontier_reg;
    logic [CNT_W-1:0]   frontier_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic [IDX_W-1:0]   emit_idx_reg;
    logic [IDX_W-1:0]   emit_idx_next;
    logic [VALUE_W-1:0] carry_reg;
    logic [VALUE_W-1:0] carry_next;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic               accept;
    logic               out_of_order;
    logic [CNT_W-1:0]   frontier_inc;
    logic               run_done;
    logic               emit_last;
    logic               push_valid;
    logic               push_ready;
    out_item_t          push_item;
    logic               cmp_pos_ok;
    logic               emit_final;
    logic               idle_empty;

    assign accept       = item_valid && !item_stall;
    assign out_of_order = $signed(rdata_reg) > $signed(carry_reg);
    assign frontier_inc = frontier_reg + CNT_W'(1);
    assign run_done     = (frontier_inc == count_reg);
    assign emit_last    = (CNT_W'(emit_idx_reg) == (count_reg - CNT_W'(1)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && item.last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = (count_reg <= CNT_W'(1)) ? ST_EMIT_RD : ST_TAKE;
            end
            ST_TAKE:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (out_of_order)
                begin
                    state_next = (pos_reg == IDX_W'(1)) ? ST_PLACE : ST_CMP;
                end
                else
                begin
                    state_next = run_done ? ST_EMIT_RD : ST_TAKE;
                end
            end
            ST_PLACE:
            begin
                state_next = run_done ? ST_EMIT_RD : ST_TAKE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (push_ready)
                begin
                    state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Datapath, store access and handshake outputs
    always_comb
    begin
        count_next    = count_reg;
        frontier_next = frontier_reg;
        pos_next      = pos_reg;
        emit_idx_next = emit_idx_reg;
        carry_next    = carry_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = carry_reg;
        item_stall    = 1'b1;
        push_valid    = 1'b0;
        push_item     = '{value_res: rdata_reg, last_res: emit_last};
        case (state_reg)
            ST_LOAD:
            begin
                item_stall = 1'b0;
                // Store while there is room, drop otherwise
                if (accept && (count_reg < CNT_W'(DEPTH)))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    wr_data    = item.value;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_START:
            begin
                emit_idx_next = '0;
                frontier_next = CNT_W'(1);
                if (count_reg > CNT_W'(1))
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(1);
                end
            end
            ST_TAKE:
            begin
                // Pick up the element to walk back and fetch its left neighbour
                carry_next = rdata_reg;
                pos_next   = frontier_reg[IDX_W-1:0];
                rd_en      = 1'b1;
                rd_addr    = frontier_reg[IDX_W-1:0] - IDX_W'(1);
            end
            ST_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (out_of_order)
                begin
                    // Swap: shift the neighbour right and step back
                    wr_data  = rdata_reg;
                    pos_next = pos_reg - IDX_W'(1);
                    if (pos_reg != IDX_W'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pos_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    // In order: drop the carried element here and advance
                    wr_data       = carry_reg;
                    frontier_next = frontier_inc;
                    if (!run_done)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = frontier_inc[IDX_W-1:0];
                    end
                end
            end
            ST_PLACE:
            begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg;
                wr_data       = carry_reg;
                frontier_next = frontier_inc;
                if (!run_done)
                begin
                    rd_en   = 1'b1;
                    rd_addr = frontier_inc[IDX_W-1:0];
                end
            end
            ST_EMIT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = emit_idx_reg;
            end
            ST_EMIT_OUT:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    emit_idx_next = emit_idx_reg + IDX_W'(1);
                    if (emit_last)
                    begin
                        count_next    = '0;
                        frontier_next = '0;
                        emit_idx_next = '0;
                    end
                end
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            frontier_reg <= '0;
            pos_reg      <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            frontier_reg <= frontier_next;
            pos_reg      <= pos_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    // Element store: one write, one registered read; the sequencer never
    // reads the entry it writes in the same cycle, so no bypass is needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    gse_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_valid   (push_valid),
        .push_item    (push_item),
        .push_ready   (push_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Terms for the checks below
    assign cmp_pos_ok = (pos_reg != '0) && (CNT_W'(pos_reg) <= frontier_reg);
    assign emit_final = (state_reg == ST_EMIT_OUT) && push_ready && emit_last;
    assign idle_empty = (state_reg == ST_LOAD) && (count_reg == '0);

    `GSE_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `GSE_ASSERT_IMPL(a_no_rw_clash, clk, rst_n, wr_en && rd_en, wr_addr != rd_addr)
    `GSE_ASSERT_IMPL(a_cmp_pos, clk, rst_n, state_reg == ST_CMP, cmp_pos_ok)
    `GSE_ASSERT_NEXT(a_emit_done, clk, rst_n, emit_final, idle_empty)

endmodule

`default_nettype wire

>>> dv/gnome_sort_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gnome_sort_engine_tb
// Self-checking bench for the gnome sort engine. Streams runs of signed values
// into the block and checks every sorted result against a behavioural sorter
// kept in step with each accepted request.
// ----------------------------------------------------------------------------

module gnome_sort_engine_tb;
    import gse_pkg::*;

    localparam int                        REQUEST_TARGET = 370;
    localparam int                        HOLD_CYCLES    = 400;
    localparam int                        SETTLE_CYCLES  = 40;
    localparam int                        REPORT_LIMIT   = 10;
    localparam logic signed [VALUE_W-1:0] VAL_MAX        = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] VAL_MIN        = 32'sh8000_0000;
    localparam int                        N_ROWS         = 15;

    typedef enum int {
        STYLE_WIDE,
        STYLE_NARROW,
        STYLE_EXTREMES,
        STYLE_RISING,
        STYLE_FALLING
    } value_style_e;

    // One directed request; typed_value is the known result of a one-value run
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      typed;
        logic signed [VALUE_W-1:0] typed_value;
    } directed_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    // Run being collected, and sorted values still owed by the block
    logic signed [VALUE_W-1:0] held_values [$];
    out_item_t                 sorted_pending [$];

    int  requests_sent    = 0;
    int  requests_dropped = 0;
    int  runs_sent        = 0;
    int  longest_run      = 0;
    int  results_checked  = 0;
    int  mismatches       = 0;
    int  burst_left       = 0;
    bit  hold_off_req     = 1'b0;

    directed_row_t directed_rows [N_ROWS] = '{
        '{VAL_MAX, 1'b1, 1'b1, VAL_MAX},
        '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
        '{32'sd0,  1'b1, 1'b1, 32'sd0},
        '{-32'sd1, 1'b1, 1'b1, -32'sd1},
        '{32'sd1,  1'b0, 1'b0, 32'sd0},
        '{32'sd2,  1'b1, 1'b0, 32'sd0},
        '{32'sd5,  1'b0, 1'b0, 32'sd0},
        '{-32'sd5, 1'b1, 1'b0, 32'sd0},
        '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
        '{32'sd0,  1'b0, 1'b0, 32'sd0},
        '{VAL_MIN, 1'b0, 1'b0, 32'sd0},
        '{-32'sd1, 1'b1, 1'b0, 32'sd0},
        '{32'sd3,  1'b0, 1'b0, 32'sd0},
        '{32'sd3,  1'b0, 1'b0, 32'sd0},
        '{32'sd3,  1'b1, 1'b0, 32'sd0}
    };

    gnome_sort_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Collect one request; on the last one, gnome-sort the run and queue it
    function automatic void sort_run_on_last(input in_item_t req);
        logic signed [VALUE_W-1:0] run_vals [$];
        logic signed [VALUE_W-1:0] swap_val;
        out_item_t                 res;
        int                        pos;
        if (held_values.size() < DEPTH)
            held_values.push_back(req.value);
        else
            requests_dropped++;
        if (!req.last)
            return;
        run_vals = held_values;
        pos = 0;
        while (pos < run_vals.size())
        begin
            if (pos == 0)
                pos = 1;
            else if (run_vals[pos] >= run_vals[pos-1])
                pos++;
            else
            begin
                swap_val        = run_vals[pos];
                run_vals[pos]   = run_vals[pos-1];
                run_vals[pos-1] = swap_val;
                pos--;
            end
        end
        foreach (run_vals[k])
        begin
            res.value_res = run_vals[k];
            res.last_res  = (k == run_vals.size() - 1);
            sorted_pending.push_back(res);
        end
        if (run_vals.size() > longest_run)
            longest_run = run_vals.size();
        runs_sent++;
        held_values.delete();
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value(input value_style_e style,
                                                            input int k, input int len);
        logic signed [VALUE_W-1:0] corner [7];
        corner = '{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1, 32'sd1, VAL_MIN + 1, VAL_MAX - 1};
        case (style)
            STYLE_NARROW:   return int'($urandom_range(0, 8)) - 4;
            STYLE_EXTREMES: return corner[$urandom_range(0, 6)];
            STYLE_RISING:   return k * 4099 - 100000 + int'($urandom_range(0, 3));
            STYLE_FALLING:  return (len - k) * 3001 - 50000;
            default:        return $urandom;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch (%s) at %0t: expected value %0d last %0b, got value %0d last %0b",
                     what, $realtime, want.value_res, want.last_res,
                     got.value_res, got.last_res);
    endtask

    // Offer one request, idling between bursts, and hold it until taken
    task automatic offer_request(input in_item_t req, input logic typed,
                                 input logic signed [VALUE_W-1:0] typed_value);
        int        gap;
        out_item_t known;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        requests_sent++;
        sort_run_on_last(req);
        // A one-value run has an answer known up front
        if (typed)
        begin
            void'(sorted_pending.pop_back());
            known.value_res = typed_value;
            known.last_res  = 1'b1;
            sorted_pending.push_back(known);
        end
    endtask

    // Drop valid and wait for the block to hand back everything owed
    task automatic drain_pause();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sorted_pending.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: stall patterns in phases, plus one long hold on request
    initial
    begin : result_side
        int           hold_left;
        int           phase_left;
        int           stall_mode;
        hold_left    = 0;
        phase_left   = 0;
        stall_mode   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                case (stall_mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // Check each accepted result against the oldest owed value
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (sorted_pending.size() == 0)
            begin
                want = '0;
                flag_mismatch("unexpected result", want, result);
            end
            else
            begin
                want = sorted_pending.pop_front();
                results_checked++;
                if (result.value_res !== want.value_res)
                    flag_mismatch("value_res", want, result);
                if (result.last_res !== want.last_res)
                    flag_mismatch("last_res", want, result);
            end
        end
    end

    // Stimulus: directed rows, then random runs
    initial
    begin : request_side
        in_item_t     req;
        value_style_e style;
        int           run_len;
        int           run_idx;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
        begin
            req.value = directed_rows[r].value;
            req.last  = directed_rows[r].last;
            offer_request(req, directed_rows[r].typed, directed_rows[r].typed_value);
        end

        run_idx = 0;
        while (requests_sent < REQUEST_TARGET)
        begin
            style   = value_style_e'($urandom_range(0, 4));
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 8);
            // Long receiver hold while the sender keeps offering
            if (run_idx == 3)
            begin
                hold_off_req = 1'b1;
                run_len      = 10;
            end
            // Full store in reverse order: the longest sort
            else if (run_idx == 8)
            begin
                style   = STYLE_FALLING;
                run_len = DEPTH;
            end
            // Overfill the store after a full drain
            else if (run_idx == 15)
            begin
                drain_pause();
                style   = STYLE_WIDE;
                run_len = DEPTH + 6;
            end
            else if (run_idx == 24)
            begin
                style   = STYLE_WIDE;
                run_len = DEPTH;
            end
            for (int k = 0; k < run_len; k++)
            begin
                req.value = pick_value(style, k, run_len);
                req.last  = (k == run_len - 1);
                offer_request(req, 1'b0, '0);
            end
            run_idx++;
        end

        drain_pause();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d requests in %0d runs (longest %0d), %0d dropped past capacity",
                 requests_sent, runs_sent, longest_run, requests_dropped);
        $display("checked %0d sorted results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Give up if the block stops making progress
    initial
    begin : run_limit
        #2_000_000;
        $display("timeout with %0d results still owed", sorted_pending.size());
        $display("status: fail");
        $finish;
    end

endmodule

>>> gnome_sort_engine.f
+incdir+rtl
rtl/gse_pkg.sv
rtl/gse_out_stage.sv
rtl/gnome_sort_engine.sv
dv/gnome_sort_engine_tb.sv
